/* sv/sts_pkg.sv */
// Shared types, codes and scan functions for the source token scanner.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int LEN_W = 7;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Token types
    localparam logic [3:0] TT_WORD      = 4'd0;
    localparam logic [3:0] TT_OPERATOR  = 4'd1;
    localparam logic [3:0] TT_KEYWORD   = 4'd2;
    localparam logic [3:0] TT_STRING    = 4'd3;
    localparam logic [3:0] TT_PERIOD    = 4'd4;
    localparam logic [3:0] TT_COMMA     = 4'd5;
    localparam logic [3:0] TT_SEMICOLON = 4'd6;
    localparam logic [3:0] TT_NEWLINE   = 4'd7;
    localparam logic [3:0] TT_BRK_OPEN  = 4'd8;
    localparam logic [3:0] TT_BRK_CLOSE = 4'd9;
    localparam logic [3:0] TT_PAR_OPEN  = 4'd10;
    localparam logic [3:0] TT_PAR_CLOSE = 4'd11;
    localparam logic [3:0] TT_DOLLAR    = 4'd12;
    localparam logic [3:0] TT_CARET     = 4'd13;
    localparam logic [3:0] TT_BAD       = 4'd14;
    localparam logic [3:0] TT_EOF       = 4'd15;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN     = 3'd1;
    localparam logic [2:0] ERR_DQUOTE      = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd3;
    localparam logic [2:0] ERR_EOF_IN_STR  = 3'd4;

    // Characters with a role of their own
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_OPER = 3'd2,
        MODE_STR  = 3'd3,
        MODE_STRC = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CLS_WORD,
        CLS_SYM,
        CLS_SPEC,
        CLS_SPACE,
        CLS_QUOTE,
        CLS_DQUOTE,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [3:0] ttype;
        logic [2:0] err;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]       n;
        result_t          r0;
        result_t          r1;
        mode_t            mode;
        logic [LEN_W-1:0] len;
    } step_t;

    function automatic cls_t classify(logic [7:0] b);
        cls_t c;
        priority if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                     (b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == CH_COLON)
        begin
            c = CLS_WORD;
        end
        else
        begin
            unique case (b)
                8'h7E, 8'h21, 8'h40, 8'h23, 8'h25, 8'h26, 8'h2A, 8'h2B,
                8'h2D, 8'h3D, 8'h7C, 8'h3C, 8'h3E, 8'h2F, 8'h3F:
                    c = CLS_SYM;
                8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                8'h3B, 8'h2E, 8'h2C, 8'h24, 8'h5E, 8'h0A:
                    c = CLS_SPEC;
                8'h20, 8'h09:
                    c = CLS_SPACE;
                CH_QUOTE:
                    c = CLS_QUOTE;
                CH_DQUOTE:
                    c = CLS_DQUOTE;
                default:
                    c = CLS_BAD;
            endcase
        end
        return c;
    endfunction

    function automatic logic [3:0] special_type(logic [7:0] b);
        logic [3:0] t;
        unique case (b)
            8'h2E:   t = TT_PERIOD;
            8'h2C:   t = TT_COMMA;
            8'h3B:   t = TT_SEMICOLON;
            8'h0A:   t = TT_NEWLINE;
            8'h5B:   t = TT_BRK_OPEN;
            8'h5D:   t = TT_BRK_CLOSE;
            8'h28:   t = TT_PAR_OPEN;
            8'h29:   t = TT_PAR_CLOSE;
            8'h24:   t = TT_DOLLAR;
            8'h5E:   t = TT_CARET;
            default: t = TT_BAD;
        endcase
        return t;
    endfunction

    // Append one result; a third one cannot arise and is dropped.
    function automatic step_t emit(step_t s, logic [1:0] k, logic [7:0] ch,
                                   logic [3:0] t, logic [2:0] e);
        step_t o;
        result_t r;
        o = s;
        r.kind  = k;
        r.ch    = ch;
        r.ttype = t;
        r.err   = e;
        r.last  = 1'b0;
        unique case (s.n)
            2'd0:
            begin
                o.r0 = r;
                o.n  = 2'd1;
            end
            2'd1:
            begin
                o.r1 = r;
                o.n  = 2'd2;
            end
            default:
            begin
                o.n = s.n;
            end
        endcase
        return o;
    endfunction

    function automatic step_t append(step_t s, logic [7:0] b, logic [LEN_W-1:0] max_len);
        step_t o;
        if (s.len < max_len)
        begin
            o = emit(s, KIND_BYTE, b, TT_WORD, ERR_NONE);
            o.len = s.len + LEN_W'(1);
        end
        else
        begin
            o = emit(s, KIND_ERR, CH_NUL, TT_WORD, ERR_TOO_LONG);
        end
        return o;
    endfunction

    function automatic step_t finish(step_t s, logic [3:0] t);
        step_t o;
        o = emit(s, KIND_END, CH_NUL, t, ERR_NONE);
        o.mode = MODE_IDLE;
        o.len  = '0;
        return o;
    endfunction

    function automatic step_t start(step_t s, logic [7:0] b, cls_t c,
                                    logic [LEN_W-1:0] max_len);
        step_t o;
        o = s;
        o.mode = MODE_IDLE;
        o.len  = '0;
        unique case (c)
            CLS_SPACE:
            begin
                o = o;
            end
            CLS_BAD:
            begin
                o = emit(o, KIND_ERR, CH_NUL, TT_WORD, ERR_UNKNOWN);
            end
            CLS_DQUOTE:
            begin
                o = emit(o, KIND_ERR, CH_NUL, TT_WORD, ERR_DQUOTE);
            end
            CLS_SPEC:
            begin
                o = emit(o, KIND_END, CH_NUL, special_type(b), ERR_NONE);
            end
            CLS_QUOTE:
            begin
                o.mode = MODE_STR;
            end
            CLS_WORD:
            begin
                if (b == CH_COLON)
                begin
                    o = emit(o, KIND_END, CH_NUL, TT_KEYWORD, ERR_NONE);
                end
                else
                begin
                    o.mode = MODE_WORD;
                    o = append(o, b, max_len);
                end
            end
            default:
            begin
                o.mode = MODE_OPER;
                o = append(o, b, max_len);
            end
        endcase
        return o;
    endfunction

    function automatic step_t in_run(step_t s, logic [7:0] b, cls_t c, cls_t own,
                                     logic [3:0] t, logic [LEN_W-1:0] max_len);
        step_t o;
        if (c == own)
        begin
            if (own == CLS_WORD && b == CH_COLON)
            begin
                o = finish(s, TT_KEYWORD);
            end
            else
            begin
                o = append(s, b, max_len);
            end
        end
        else if (c == CLS_BAD)
        begin
            o = emit(s, KIND_ERR, CH_NUL, TT_WORD, ERR_UNKNOWN);
            o = finish(o, t);
        end
        else if (c == CLS_SPACE)
        begin
            o = finish(s, t);
        end
        else
        begin
            o = finish(s, t);
            o = start(o, b, c, max_len);
        end
        return o;
    endfunction

    // Full work for one request: up to two results and the next scan state.
    function automatic step_t scan_step(logic eoi, logic [7:0] b, mode_t mode,
                                        logic [LEN_W-1:0] len,
                                        logic [LEN_W-1:0] max_len);
        step_t s;
        cls_t  c;
        s      = '0;
        s.mode = mode;
        s.len  = len;
        c      = classify(b);
        if (eoi)
        begin
            if (mode == MODE_STR)
            begin
                s = emit(s, KIND_ERR, CH_NUL, TT_WORD, ERR_EOF_IN_STR);
            end
            else if (mode == MODE_STRC)
            begin
                s = emit(s, KIND_END, CH_NUL, TT_STRING, ERR_NONE);
            end
            s = finish(s, TT_EOF);
        end
        else
        begin
            unique case (mode)
                MODE_WORD:
                begin
                    s = in_run(s, b, c, CLS_WORD, TT_WORD, max_len);
                end
                MODE_OPER:
                begin
                    s = in_run(s, b, c, CLS_SYM, TT_OPERATOR, max_len);
                end
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                    begin
                        s.mode = MODE_STRC;
                    end
                    else
                    begin
                        s = append(s, b, max_len);
                    end
                end
                MODE_STRC:
                begin
                    if (b == CH_COLON)
                    begin
                        s = finish(s, TT_KEYWORD);
                    end
                    else
                    begin
                        s = finish(s, TT_STRING);
                        s = start(s, b, c, max_len);
                    end
                end
                default:
                begin
                    s = start(s, b, c, max_len);
                end
            endcase
        end
        s.r0.last = (s.n == 2'd1);
        s.r1.last = (s.n == 2'd2);
        return s;
    endfunction

endpackage

/* sv/source_token_scanner.sv */
// Top level of the source token scanner: input register, scan logic, result queue.
`timescale 1ns / 1ps

// Streaming tokenizer. The request channel (req_valid/req_ready) carries one
// source byte per request, or an end-of-input mark in end_of_input. The result
// channel (res_valid/res_ready) carries token bytes, token ends with their
// type, and error reports; last marks the final result of a request.
//
// A request accepted lands in the input register, is scanned there by
// combinational logic, and its results enter the result queue, whose head
// drives the result ports. Throughput: one request per cycle while the
// three-entry result queue holds at most one result; the input register
// advances only then, so a request that yields two results holds the next
// one back. Requests that yield no result (blanks between tokens, quote
// marks) still pass through the input register.
//
// Reset clears the scan mode to idle, the token length to zero and empties
// the input register and result queue. Stalled results wait in the queue;
// with two or more queued and a request held, req_ready drops and scan state holds.
module source_token_scanner #(
    parameter int MAX_TOKEN_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       end_of_input,
    input  logic [7:0] byte_req,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] kind,
    output logic [7:0] char_out,
    output logic [3:0] token_type,
    output logic [2:0] error_code,
    output logic       last
);
    import sts_pkg::*;

    localparam int QDEPTH = 3;

    // Input register
    logic        in_vld_reg;
    logic        in_vld_next;
    logic        eoi_reg;
    logic [7:0]  byte_reg;

    // Scan state
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    // Result queue, head at entry zero
    result_t     q_reg [QDEPTH];
    result_t     q_next [QDEPTH];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [1:0]  base;

    logic        req_acc;
    logic        res_pop;
    logic        advance;
    step_t       step;

    // Scan the held request only when the queue can take two more results.
    assign advance   = in_vld_reg && (cnt_reg <= 2'd1);
    assign req_ready = !in_vld_reg || advance;
    assign req_acc   = req_valid && req_ready;
    assign res_valid = (cnt_reg != 2'd0);
    assign res_pop   = res_valid && res_ready;

    assign step = scan_step(eoi_reg, byte_reg, mode_reg, len_reg,
                            LEN_W'(MAX_TOKEN_LEN));

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_acc)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        if (advance)
        begin
            mode_next = step.mode;
            len_next  = step.len;
        end
    end

    // Shift out the head on a pop, then drop the new results behind what stays.
    always_comb
    begin
        q_next[0] = res_pop ? q_reg[1] : q_reg[0];
        q_next[1] = res_pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        base      = cnt_reg - {1'b0, res_pop};
        cnt_next  = base;
        if (advance)
        begin
            for (int i = 0; i < QDEPTH; i++)
            begin
                if (step.n != 2'd0 && base == 2'(i))
                begin
                    q_next[i] = step.r0;
                end
                if (step.n == 2'd2 && base + 2'd1 == 2'(i))
                begin
                    q_next[i] = step.r1;
                end
            end
            cnt_next = base + step.n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            eoi_reg  <= end_of_input;
            byte_reg <= byte_req;
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign kind       = q_reg[0].kind;
    assign char_out   = q_reg[0].ch;
    assign token_type = q_reg[0].ttype;
    assign error_code = q_reg[0].err;
    assign last       = q_reg[0].last;

endmodule

/* sv/sts_checker.sv */
// Port-level checks for the source token scanner, bound to the top level.
`timescale 1ns / 1ps

module sts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] kind,
    input logic [7:0] char_out,
    input logic [3:0] token_type,
    input logic [2:0] error_code,
    input logic       last
);
    import sts_pkg::*;

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(char_out)
            && $stable(token_type) && $stable(error_code) && $stable(last))
        else $error("stalled result changed");

    // The second result of a request follows right after the first.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last |=> res_valid)
        else $error("second result of a request missing");

    // End of file always closes a request.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_END && token_type == TT_EOF |-> last)
        else $error("end of file token not last");

    // End inside a string is followed by the end of file token.
    a_str_eof: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && kind == KIND_ERR && error_code == ERR_EOF_IN_STR
            |=> res_valid && kind == KIND_END && token_type == TT_EOF)
        else $error("end inside string not followed by end of file");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .kind       (kind),
    .char_out   (char_out),
    .token_type (token_type),
    .error_code (error_code),
    .last       (last)
);

/* test/scanner_checker.sv */
// Result checker for the source token scanner: tracks the scan state and compares every result.
`timescale 1ns / 1ps

module scanner_checker #(
    parameter int MAX_TOKEN_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic       end_of_input,
    input  logic [7:0] byte_req,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_out,
    input  logic [3:0] token_type,
    input  logic [2:0] error_code,
    input  logic       last,
    output int         fail_count,
    output int         pending,
    output int         checked_count
);

    import sts_pkg::*;

    // Scanner state as seen from the request stream
    mode_t                scan_mode;
    logic [LEN_W-1:0]     tok_len;

    // Character tables, filled once
    cls_t                 class_of [0:255];
    logic [3:0]           special_of [0:255];

    result_t              request_results[$];
    result_t              token_results[$];

    initial
    begin : build_tables
        string op_set;
        string spec_set;
        op_set   = "~!@#%&*+-=|<>/?";
        spec_set = "()[]{};.,$^\n";
        for (int i = 0; i < 256; i++)
        begin
            class_of[i]   = CLS_BAD;
            special_of[i] = TT_BAD;
        end
        for (int i = 0; i < 26; i++)
        begin
            class_of[8'h41 + i] = CLS_WORD;
            class_of[8'h61 + i] = CLS_WORD;
        end
        for (int i = 0; i < 10; i++)
        begin
            class_of[8'h30 + i] = CLS_WORD;
        end
        class_of[8'h5F]      = CLS_WORD;
        class_of[CH_COLON]   = CLS_WORD;
        for (int i = 0; i < op_set.len(); i++)
        begin
            class_of[op_set[i]] = CLS_SYM;
        end
        for (int i = 0; i < spec_set.len(); i++)
        begin
            class_of[spec_set[i]] = CLS_SPEC;
        end
        class_of[8'h20]      = CLS_SPACE;
        class_of[8'h09]      = CLS_SPACE;
        class_of[CH_QUOTE]   = CLS_QUOTE;
        class_of[CH_DQUOTE]  = CLS_DQUOTE;
        special_of[8'h2E]    = TT_PERIOD;
        special_of[8'h2C]    = TT_COMMA;
        special_of[8'h3B]    = TT_SEMICOLON;
        special_of[8'h0A]    = TT_NEWLINE;
        special_of[8'h5B]    = TT_BRK_OPEN;
        special_of[8'h5D]    = TT_BRK_CLOSE;
        special_of[8'h28]    = TT_PAR_OPEN;
        special_of[8'h29]    = TT_PAR_CLOSE;
        special_of[8'h24]    = TT_DOLLAR;
        special_of[8'h5E]    = TT_CARET;
        scan_mode     = MODE_IDLE;
        tok_len       = '0;
        fail_count    = 0;
        checked_count = 0;
        pending       = 0;
    end

    // Type field stays zero on byte and error results.
    function automatic void put(logic [1:0] k, logic [7:0] ch, logic [3:0] t, logic [2:0] e);
        result_t r;
        r.kind  = k;
        r.ch    = ch;
        r.ttype = t;
        r.err   = e;
        r.last  = 1'b0;
        request_results.push_back(r);
    endfunction

    // Add a byte to the token, or flag it once the token is full.
    function automatic void grow(logic [7:0] b);
        if (tok_len < MAX_TOKEN_LEN)
        begin
            put(KIND_BYTE, b, TT_WORD, ERR_NONE);
            tok_len = tok_len + 1'b1;
        end
        else
        begin
            put(KIND_ERR, CH_NUL, TT_WORD, ERR_TOO_LONG);
        end
    endfunction

    function automatic void close_token(logic [3:0] t);
        put(KIND_END, CH_NUL, t, ERR_NONE);
        scan_mode = MODE_IDLE;
        tok_len   = '0;
    endfunction

    function automatic void open_token(logic [7:0] b, cls_t c);
        scan_mode = MODE_IDLE;
        tok_len   = '0;
        case (c)
            CLS_BAD:    put(KIND_ERR, CH_NUL, TT_WORD, ERR_UNKNOWN);
            CLS_DQUOTE: put(KIND_ERR, CH_NUL, TT_WORD, ERR_DQUOTE);
            CLS_SPEC:   put(KIND_END, CH_NUL, special_of[b], ERR_NONE);
            CLS_QUOTE:  scan_mode = MODE_STR;
            CLS_WORD:
            begin
                if (b == CH_COLON)
                begin
                    put(KIND_END, CH_NUL, TT_KEYWORD, ERR_NONE);
                end
                else
                begin
                    scan_mode = MODE_WORD;
                    grow(b);
                end
            end
            CLS_SYM:
            begin
                scan_mode = MODE_OPER;
                grow(b);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void continue_run(logic [7:0] b, cls_t c, cls_t own, logic [3:0] t);
        if (c == own)
        begin
            if (own == CLS_WORD && b == CH_COLON)
                close_token(TT_KEYWORD);
            else
                grow(b);
        end
        else if (c == CLS_BAD)
        begin
            put(KIND_ERR, CH_NUL, TT_WORD, ERR_UNKNOWN);
            close_token(t);
        end
        else if (c == CLS_SPACE)
        begin
            close_token(t);
        end
        else
        begin
            // The ending byte starts whatever follows.
            close_token(t);
            open_token(b, c);
        end
    endfunction

    function automatic void advance_scanner(logic eoi, logic [7:0] b);
        cls_t    c;
        result_t r;
        request_results.delete();
        c = class_of[b];
        if (eoi)
        begin
            if (scan_mode == MODE_STR)
                put(KIND_ERR, CH_NUL, TT_WORD, ERR_EOF_IN_STR);
            else if (scan_mode == MODE_STRC)
                put(KIND_END, CH_NUL, TT_STRING, ERR_NONE);
            close_token(TT_EOF);
        end
        else
        begin
            case (scan_mode)
                MODE_WORD: continue_run(b, c, CLS_WORD, TT_WORD);
                MODE_OPER: continue_run(b, c, CLS_SYM, TT_OPERATOR);
                MODE_STR:
                begin
                    if (b == CH_QUOTE)
                        scan_mode = MODE_STRC;
                    else
                        grow(b);
                end
                MODE_STRC:
                begin
                    if (b == CH_COLON)
                    begin
                        close_token(TT_KEYWORD);
                    end
                    else
                    begin
                        close_token(TT_STRING);
                        open_token(b, c);
                    end
                end
                default: open_token(b, c);
            endcase
        end
        for (int i = 0; i < request_results.size(); i++)
        begin
            r      = request_results[i];
            r.last = (i == request_results.size() - 1);
            token_results.push_back(r);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                advance_scanner(end_of_input, byte_req);
            end
            if (res_valid && res_ready)
            begin
                if (token_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d char %0h type %0d error %0d",
                           kind, char_out, token_type, error_code);
                    fail_count++;
                end
                else
                begin
                    want = token_results.pop_front();
                    checked_count++;
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (char_out !== want.ch)
                    begin
                        $error("char_out: expected %0h, got %0h", want.ch, char_out);
                        fail_count++;
                    end
                    if (token_type !== want.ttype)
                    begin
                        $error("token_type: expected %0d, got %0d", want.ttype, token_type);
                        fail_count++;
                    end
                    if (error_code !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err, error_code);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            pending <= token_results.size();
        end
    end

endmodule

/* test/testbench.sv */
// Top of the source token scanner testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    import sts_pkg::*;

    localparam int         MAX_TOKEN_LEN = 64;
    localparam int         TOTAL_ITEMS   = 1650;
    localparam int         QUIET_LIMIT   = 1000;
    localparam int         DRAIN_CYCLES  = 12;
    localparam logic [8:0] EOI_MARK      = 9'h100;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    logic       end_of_input;
    logic [7:0] byte_req;
    logic       res_valid;
    logic       res_ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [3:0] token_type;
    logic [2:0] error_code;
    logic       last;

    int         fail_count;
    int         pending;
    int         checked_count;

    int         sent_total;
    int         eoi_total;
    int         burst_left;
    logic       draining;

    // Opening cases, one request each; bit 8 marks end of input.
    logic [8:0] opening_seq [0:24] = '{
        9'h020,     // space while idle: skipped
        9'h009,     // tab while idle: skipped
        9'h041,     // word start
        9'h07A,
        9'h039,
        9'h05F,
        9'h03A,     // colon inside a word: keyword end
        9'h03A,     // colon on its own: empty keyword
        9'h02B,     // operator start
        9'h078,     // letter after an operator: operator end, then word byte
        9'h0FF,     // unknown byte ends the word: error, then word end
        9'h000,     // NUL while idle: unknown character
        9'h022,     // double quote outside a string
        9'h07B,     // brace: bad special symbol
        9'h00A,     // newline token
        9'h027,     // open a string
        9'h068,
        9'h022,     // double quote inside a string is plain content
        9'h027,     // close it
        9'h03A,     // colon right after the closing quote: keyword
        9'h027,     // empty string ...
        9'h027,
        9'h02E,     // ... closed by a period: string end, then period
        9'h02D,     // operator left open ...
        EOI_MARK    // ... until end of input
    };

    source_token_scanner #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .end_of_input(end_of_input),
        .byte_req    (byte_req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .char_out    (char_out),
        .token_type  (token_type),
        .error_code  (error_code),
        .last        (last)
    );

    scanner_checker #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) watcher (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .end_of_input (end_of_input),
        .byte_req     (byte_req),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .char_out     (char_out),
        .token_type   (token_type),
        .error_code   (error_code),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked_count(checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hand one request to the block. The sender runs in bursts: when a burst
    // is used up, drop valid for a random gap, then pick a new burst length.
    // Some bursts are long with no gap before them, so back-to-back traffic
    // gets exercised as well.
    task automatic send_request(input logic eoi, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        // Hold valid and payload until the block takes the request.
        req_valid    <= 1'b1;
        end_of_input <= eoi;
        byte_req     <= b;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_total++;
        if (eoi)
            eoi_total++;
    endtask

    // Result sink: switch among stall styles at random; always
    // ready, mostly ready, mostly stalled, and runs of either level.
    initial
    begin : result_sink
        int   style;
        int   style_left;
        int   run_left;
        logic run_level;
        style      = 0;
        style_left = 0;
        run_left   = 0;
        run_level  = 1'b1;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            if (draining)
            begin
                res_ready <= 1'b1;
            end
            else
            begin
                case (style)
                    0: res_ready <= 1'b1;
                    1: res_ready <= ($urandom_range(0, 3) != 0);
                    2: res_ready <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_level = ~run_level;
                            run_left  = $urandom_range(1, 8);
                        end
                        run_left--;
                        res_ready <= run_level;
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        string        word_set;
        string        op_set;
        string        spec_set;
        string        blank_set;
        int           piece;
        int           len;
        logic [7:0]   b;
        word_set   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";
        op_set     = "~!@#%&*+-=|<>/?";
        spec_set   = "()[]{};.,$^\n";
        blank_set  = " \t";
        sent_total = 0;
        eoi_total  = 0;
        burst_left = 0;
        draining   = 1'b0;

        req_valid    <= 1'b0;
        end_of_input <= 1'b0;
        byte_req     <= 8'h00;
        rst_n        <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_seq[i])
        begin
            send_request(opening_seq[i][8], opening_seq[i][7:0]);
        end

        // Random part: mostly well-formed tokens with random content, packed
        // back to back so that the byte ending one token starts the next,
        // with raw noise and end-of-input marks mixed in.
        while (sent_total < TOTAL_ITEMS)
        begin
            piece = $urandom_range(0, 99);
            if (piece < 38)
            begin
                // Word, sometimes long enough to overflow, sometimes a keyword.
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    send_request(1'b0, word_set[$urandom_range(0, word_set.len() - 1)]);
                end
                if ($urandom_range(0, 4) == 0)
                    send_request(1'b0, CH_COLON);
            end
            else if (piece < 53)
            begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    send_request(1'b0, op_set[$urandom_range(0, op_set.len() - 1)]);
                end
            end
            else if (piece < 66)
            begin
                // String with any content but a quote; mostly closed.
                send_request(1'b0, CH_QUOTE);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(0, 8);
                for (int i = 0; i < len; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_QUOTE)
                        b = CH_DQUOTE;
                    send_request(1'b0, b);
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    send_request(1'b0, CH_QUOTE);
                    if ($urandom_range(0, 3) == 0)
                        send_request(1'b0, CH_COLON);
                end
            end
            else if (piece < 77)
            begin
                send_request(1'b0, spec_set[$urandom_range(0, spec_set.len() - 1)]);
            end
            else if (piece < 86)
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    send_request(1'b0, blank_set[$urandom_range(0, 1)]);
                end
            end
            else if (piece < 96)
            begin
                send_request(1'b0, 8'($urandom_range(0, 255)));
            end
            else
            begin
                // The byte rides along but must be ignored.
                send_request(1'b1, 8'($urandom_range(0, 255)));
            end
        end

        // Drop valid, let the last prediction land, then drain.
        req_valid <= 1'b0;
        draining = 1'b1;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Scanned %0d requests, %0d of them end-of-input marks; %0d results checked.",
                 sent_total, eoi_total, checked_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
